/* src/cbdt_pkg.sv */
package cbdt_pkg;

	// frame geometry
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_PIXELS = MAX_WIDTH * MAX_HEIGHT;

	localparam int X_W    = $clog2(MAX_WIDTH);
	localparam int Y_W    = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = $clog2(MAX_PIXELS);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int DIST_W = $clog2(MAX_PIXELS + 2);

	// fixed field widths
	localparam int DIM_W      = 9;
	localparam int PIX_W      = 16;
	localparam int THR_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [DIM_W-1:0]  dim_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [X_W-1:0]    xcnt_t;
	typedef logic [Y_W-1:0]    ycnt_t;

	localparam dim_t MAX_W_DIM = dim_t'(MAX_WIDTH);
	localparam dim_t MAX_H_DIM = dim_t'(MAX_HEIGHT);

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FEATURE_MODE = 2'd3;

	// commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// transform kick-off with the frame geometry
	typedef struct packed {
		logic start;
		dim_t w;
		dim_t h;
		cnt_t total;
	} eng_start_t;

	// feature map write from the load path
	typedef struct packed {
		logic  en;
		addr_t addr;
		logic  feature;
	} fm_wr_t;

	// operands of the relaxation step
	typedef struct packed {
		logic  feature;
		dist_t base;
		dist_t a;
		logic  a_ok;
		dist_t b;
		logic  b_ok;
	} step_in_t;

endpackage

/* src/cbdt_step_unit.sv */
// min(base, a+1 when a_ok, b+1 when b_ok), forced to zero on a feature pixel
module cbdt_step_unit (
	input  cbdt_pkg::step_in_t op,
	output cbdt_pkg::dist_t    result
);

	cbdt_pkg::dist_t a_inc;
	cbdt_pkg::dist_t b_inc;
	cbdt_pkg::dist_t m1;
	cbdt_pkg::dist_t m2;

	always_comb begin
		a_inc  = op.a + cbdt_pkg::dist_t'(1);
		b_inc  = op.b + cbdt_pkg::dist_t'(1);
		m1     = (op.a_ok && (a_inc < op.base)) ? a_inc : op.base;
		m2     = (op.b_ok && (b_inc < m1)) ? b_inc : m1;
		result = op.feature ? '0 : m2;
	end

endmodule

/* src/cbdt_engine.sv */
// Feature map, distance store and the two-pass raster sequencer.
module cbdt_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cbdt_pkg::eng_start_t ctrl,
	input  cbdt_pkg::fm_wr_t     fm_wr,
	input  cbdt_pkg::addr_t      rd_addr,
	output cbdt_pkg::dist_t      rd_data,
	output logic                 busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD,
		ST_TURN,
		ST_BWD,
		ST_DRAIN
	} state_t;

	state_t state_q;

	cbdt_pkg::addr_t idx_q;
	cbdt_pkg::xcnt_t x_q;
	cbdt_pkg::ycnt_t y_q;
	cbdt_pkg::dim_t  w_q;
	cbdt_pkg::dim_t  h_q;
	cbdt_pkg::cnt_t  total_q;
	cbdt_pkg::dist_t far_q;
	logic            valid_s1;

	cbdt_pkg::addr_t idx_s1;
	cbdt_pkg::xcnt_t x_s1;
	cbdt_pkg::ycnt_t y_s1;
	logic            bwd_s1;
	logic            feat_s1;
	cbdt_pkg::dist_t mema_s1;
	cbdt_pkg::dist_t memb_s1;
	cbdt_pkg::dist_t prev_q;

	logic            fm_mem   [cbdt_pkg::MAX_PIXELS];
	cbdt_pkg::dist_t dist_mem [cbdt_pkg::MAX_PIXELS];

	cbdt_pkg::addr_t    addr_a;
	cbdt_pkg::addr_t    addr_b;
	cbdt_pkg::addr_t    w_ext;
	logic               last_idx;
	logic               x_last;
	logic               w_one;
	cbdt_pkg::dist_t    nb;
	cbdt_pkg::step_in_t op;
	cbdt_pkg::dist_t    step_result;

	always_comb begin
		w_ext    = cbdt_pkg::addr_t'(w_q);
		last_idx = (idx_q == cbdt_pkg::addr_t'(total_q - cbdt_pkg::cnt_t'(1)));
		x_last   = (cbdt_pkg::dim_t'(x_q) == (w_q - cbdt_pkg::dim_t'(1)));
		addr_a   = (state_q == ST_IDLE) ? rd_addr : idx_q;
		addr_b   = (state_q == ST_BWD) ? (idx_q + w_ext) : (idx_q - w_ext);
	end

	// vertical neighbour: with one column it is the pixel just done
	always_comb begin
		w_one      = (w_q == cbdt_pkg::dim_t'(1));
		nb         = w_one ? prev_q : memb_s1;
		op.feature = feat_s1;
		op.base    = bwd_s1 ? mema_s1 : far_q;
		op.a       = nb;
		op.a_ok    = bwd_s1 ? ((cbdt_pkg::dim_t'(y_s1) + cbdt_pkg::dim_t'(1)) < h_q)
		                    : (y_s1 != '0);
		op.b       = prev_q;
		op.b_ok    = bwd_s1 ? ((cbdt_pkg::dim_t'(x_s1) + cbdt_pkg::dim_t'(1)) < w_q)
		                    : (x_s1 != '0);
	end

	cbdt_step_unit u_step (
		.op     (op),
		.result (step_result)
	);

	always_ff @(posedge clk) begin
		if (fm_wr.en) begin
			fm_mem[fm_wr.addr] <= fm_wr.feature;
		end
		feat_s1 <= fm_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			dist_mem[idx_s1] <= step_result;
		end
		mema_s1 <= dist_mem[addr_a];
		memb_s1 <= dist_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		x_s1   <= x_q;
		y_s1   <= y_q;
		bwd_s1 <= (state_q == ST_BWD);
		if (valid_s1) begin
			prev_q <= step_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			w_q      <= '0;
			h_q      <= '0;
			total_q  <= '0;
			far_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					valid_s1 <= 1'b0;
					if (ctrl.start) begin
						w_q     <= ctrl.w;
						h_q     <= ctrl.h;
						total_q <= ctrl.total;
						far_q   <= cbdt_pkg::dist_t'(ctrl.total) + cbdt_pkg::dist_t'(1);
						idx_q   <= '0;
						x_q     <= '0;
						y_q     <= '0;
						state_q <= ST_FWD;
					end
				end
				ST_FWD: begin
					valid_s1 <= 1'b1;
					if (last_idx) begin
						state_q <= ST_TURN;
					end else begin
						idx_q <= idx_q + cbdt_pkg::addr_t'(1);
						if (x_last) begin
							x_q <= '0;
							y_q <= y_q + cbdt_pkg::ycnt_t'(1);
						end else begin
							x_q <= x_q + cbdt_pkg::xcnt_t'(1);
						end
					end
				end
				ST_TURN: begin
					// bubble: last forward write lands before the backward reads
					valid_s1 <= 1'b0;
					idx_q    <= cbdt_pkg::addr_t'(total_q - cbdt_pkg::cnt_t'(1));
					x_q      <= cbdt_pkg::xcnt_t'(w_q - cbdt_pkg::dim_t'(1));
					y_q      <= cbdt_pkg::ycnt_t'(h_q - cbdt_pkg::dim_t'(1));
					state_q  <= ST_BWD;
				end
				ST_BWD: begin
					valid_s1 <= 1'b1;
					if (idx_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q - cbdt_pkg::addr_t'(1);
						if (x_q == '0) begin
							x_q <= cbdt_pkg::xcnt_t'(w_q - cbdt_pkg::dim_t'(1));
							y_q <= y_q - cbdt_pkg::ycnt_t'(1);
						end else begin
							x_q <= x_q - cbdt_pkg::xcnt_t'(1);
						end
					end
				end
				ST_DRAIN: begin
					valid_s1 <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: begin
					valid_s1 <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign rd_data = mema_s1;

	a_s1_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q != ST_IDLE))
		else $error("step result written outside a pass");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> (state_q == ST_IDLE))
		else $error("transform started while running");

	a_fm_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fm_wr.en |-> (state_q == ST_IDLE))
		else $error("feature map written during transform");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cbdt_pkg::cnt_t'(idx_s1) < total_q))
		else $error("distance write beyond frame");

	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(($past(state_q) == ST_FWD) && (state_q != ST_FWD)) |-> (state_q == ST_TURN))
		else $error("backward pass entered without turn bubble");

endmodule

/* src/city_block_distance_transform_top.sv */
// City-block distance transform. Pixels are loaded one per start beat in
// row-major order (command = load); each becomes a feature bit (nonzero, or
// below threshold in threshold mode). The beat carrying the last pixel of
// the frame kicks off the transform and busy stays high through a forward
// raster pass of one pixel per cycle, a turn-around state, a backward
// raster pass of one pixel per cycle and a drain state. The pace is set
// by the one write port and two read ports on the distance store and the
// one shared min/increment unit that every pixel goes through. After that,
// each read beat (command = read) is taken while busy is low and its
// distance appears with result_valid in the cycle after the beat, for one
// cycle only; there is no back-pressure on the result side, so the
// receiver must catch every beat. last marks the final distance of the
// frame, after which a new frame may be loaded. Loads while a frame waits
// to be read and reads with no frame ready are taken but give nothing.
// Frame size is sampled at the last load; width and height of 0 act as 1,
// above 256 as 256. Configuration beats are always taken (cfg_ready is
// tied high) and must only come while the block is idle.
module city_block_distance_transform_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [cbdt_pkg::PIX_W-1:0]           pixel,
	// results
	output logic                                 result_valid,
	output cbdt_pkg::dist_t                      distance,
	output logic                                 last,
	// configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cbdt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cbdt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// configuration registers
	cbdt_pkg::dim_t                image_width_q;
	cbdt_pkg::dim_t                image_height_q;
	logic [cbdt_pkg::THR_W-1:0]    threshold_q;
	logic                          feature_mode_q;

	// frame bookkeeping
	cbdt_pkg::cnt_t load_ptr_q;
	cbdt_pkg::cnt_t read_ptr_q;
	cbdt_pkg::cnt_t frame_total_q;
	logic           frame_ready_q;
	logic           result_valid_q;
	logic           last_q;

	cbdt_pkg::dim_t       w_eff;
	cbdt_pkg::dim_t       h_eff;
	cbdt_pkg::cnt_t       total;
	logic                 accept;
	logic                 load_acc;
	logic                 read_acc;
	logic                 has_room;
	cbdt_pkg::cnt_t       load_nxt;
	logic                 frame_done;
	logic                 is_feat;
	logic                 read_last;
	logic                 eng_busy;
	cbdt_pkg::eng_start_t ctrl;
	cbdt_pkg::fm_wr_t     fm_wr;
	cbdt_pkg::dist_t      rd_data;

	assign cfg_ready = 1'b1;

	// clamp the programmed size; product always fits the pixel counter
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = cbdt_pkg::dim_t'(1);
		end else if (image_width_q > cbdt_pkg::MAX_W_DIM) begin
			w_eff = cbdt_pkg::MAX_W_DIM;
		end else begin
			w_eff = image_width_q;
		end
		if (image_height_q == '0) begin
			h_eff = cbdt_pkg::dim_t'(1);
		end else if (image_height_q > cbdt_pkg::MAX_H_DIM) begin
			h_eff = cbdt_pkg::MAX_H_DIM;
		end else begin
			h_eff = image_height_q;
		end
		total = cbdt_pkg::cnt_t'(w_eff) * cbdt_pkg::cnt_t'(h_eff);
	end

	always_comb begin
		accept   = start && !eng_busy;
		load_acc = accept && (command == cbdt_pkg::CMD_LOAD) && !frame_ready_q;
		read_acc = accept && (command == cbdt_pkg::CMD_READ) && frame_ready_q
		           && (read_ptr_q < frame_total_q);
		has_room = (load_ptr_q < total);
		// size shrunk under a partial load: the beat closes the frame, pixel dropped
		load_nxt   = has_room ? (load_ptr_q + cbdt_pkg::cnt_t'(1)) : total;
		frame_done = load_acc && (load_nxt >= total);
		is_feat    = feature_mode_q ? (pixel < threshold_q) : (pixel != '0);
		read_last  = ((read_ptr_q + cbdt_pkg::cnt_t'(1)) >= frame_total_q);

		fm_wr.en      = load_acc && has_room;
		fm_wr.addr    = load_ptr_q[cbdt_pkg::ADDR_W-1:0];
		fm_wr.feature = is_feat;

		ctrl.start = frame_done;
		ctrl.w     = w_eff;
		ctrl.h     = h_eff;
		ctrl.total = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= cbdt_pkg::MAX_W_DIM;
			image_height_q <= cbdt_pkg::MAX_H_DIM;
			threshold_q    <= '0;
			feature_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cbdt_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[cbdt_pkg::DIM_W-1:0];
				end
				cbdt_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[cbdt_pkg::DIM_W-1:0];
				end
				cbdt_pkg::REG_THRESHOLD: begin
					threshold_q <= cfg_data[cbdt_pkg::THR_W-1:0];
				end
				cbdt_pkg::REG_FEATURE_MODE: begin
					feature_mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q     <= '0;
			read_ptr_q     <= '0;
			frame_total_q  <= '0;
			frame_ready_q  <= 1'b0;
			result_valid_q <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			result_valid_q <= read_acc;
			if (load_acc) begin
				load_ptr_q <= load_nxt;
				if (frame_done) begin
					frame_ready_q <= 1'b1;
					frame_total_q <= total;
					read_ptr_q    <= '0;
				end
			end
			if (read_acc) begin
				last_q <= read_last;
				if (read_last) begin
					frame_ready_q <= 1'b0;
					read_ptr_q    <= '0;
					load_ptr_q    <= '0;
				end else begin
					read_ptr_q <= read_ptr_q + cbdt_pkg::cnt_t'(1);
				end
			end
		end
	end

	cbdt_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.fm_wr   (fm_wr),
		.rd_addr (read_ptr_q[cbdt_pkg::ADDR_W-1:0]),
		.rd_data (rd_data),
		.busy    (eng_busy)
	);

	assign busy         = eng_busy;
	assign result_valid = result_valid_q;
	assign distance     = rd_data;
	assign last         = last_q;

endmodule
